>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that carry concurrent checks.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while the active-low reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Shorthand for modules using the house clock and reset names.
`define ASSERT_TOP(lbl, prop, msg) `ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

>>> hw/rtl/rtd_pkg.sv
// Shared constants, codes and types of the RTD resistance to temperature core.
// Depends on nothing; imported by the fraction divider and the top level.
`timescale 1ns / 1ps

package rtd_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 1051;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Field widths
    localparam int RES_W       = 16;
    localparam int ENTRY_IDX_W = 11;
    localparam int TEMP_W      = 15;
    localparam int STATUS_W    = 2;

    // Fraction divider: dividend is diff * 10, quotient never exceeds ten
    localparam int DVD_W  = RES_W + 4;
    localparam int QUOT_W = 4;
    localparam int STEP_W = $clog2(QUOT_W);

    // Temperature scaling
    localparam int TENTHS        = 10;
    localparam int DEGREE_OFFSET = 200;
    localparam int TEMP_BELOW    = -2000;
    localparam int TEMP_ABOVE    = 8500;
    localparam int TEMP_MAX      = 16383;
    localparam int CALC_W        = (IDX_W + 6 > 16) ? IDX_W + 6 : 16;

    // Request kinds
    localparam logic KIND_CONVERT = 1'b0;
    localparam logic KIND_WRITE   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSIDE = 2'd0,
        ST_BELOW  = 2'd1,
        ST_ABOVE  = 2'd2
    } t_status;

    typedef struct packed {
        logic              load;
        logic [DVD_W-1:0]  dividend;
        logic [RES_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> hw/rtl/rtd_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// Depends on nothing; holds the resistance table of the core.
`timescale 1ns / 1ps

module rtd_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/rtd_frac_div.sv
// Restoring divider for the interpolation fraction, one quotient bit a cycle.
// Depends on rtd_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module rtd_frac_div import rtd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_active;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_rem;
    logic [RES_W-1:0]  r_divisor;
    logic [QUOT_W-1:0] r_quot;

    logic [DVD_W-1:0]  shifted;
    logic [DVD_W:0]    trial;
    logic              fits;

    // Trial subtract of the divisor aligned to the current quotient bit
    assign shifted = DVD_W'(r_divisor) << r_step;
    assign trial   = {1'b0, r_rem} - {1'b0, shifted};
    assign fits    = !trial[DVD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.load) begin
                r_active  <= 1'b1;
                r_step    <= STEP_W'(QUOT_W - 1);
                r_rem     <= i_req.dividend;
                r_divisor <= i_req.divisor;
                r_quot    <= '0;
            end else if (r_active) begin
                if (fits) begin
                    r_rem          <= trial[DVD_W-1:0];
                    r_quot[r_step] <= 1'b1;
                end
                if (r_step == '0) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
                r_step <= r_step - 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

>>> hw/rtl/rtd_resistance_to_temperature_core.sv
// Top level of the RTD resistance to temperature core: sequencer, table RAM
// and fraction divider. Depends on rtd_pkg, rtd_ram, rtd_frac_div, assert_macros.svh.
//
// Usage:
//   Present a request on i_kind / i_resistance / i_entry_index / i_entry_value
//   with start high; it is taken at the clock edge where busy is low.
//   A write request (i_kind = 1) stores i_entry_value at i_entry_index and gives
//   no result; indexes past the table end are dropped. busy stays high through
//   the write state after the accept. Load every table entry before converting.
//   A convert request (i_kind = 0) gives exactly one result: o_valid pulses for
//   one cycle with o_temperature (tenths of a degree) and o_status.
//   Order from accept to result: below the table after the first end read, above
//   it after the second, else two end reads, the search probes (one RAM read port),
//   top read, divider load, four divider steps, done and result; a flat interval
//   skips the divider.
//   Throughput: one request in flight; the next can be taken in the cycle the
//   result strobe is high.
//   The receiver cannot stall: o_valid lasts one cycle; the result fields are held.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle and clears
//   the strobe; the table contents survive reset and are undefined until loaded.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rtd_resistance_to_temperature_core import rtd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_kind,
    input  logic [RES_W-1:0]         i_resistance,
    input  logic [ENTRY_IDX_W-1:0]   i_entry_index,
    input  logic [RES_W-1:0]         i_entry_value,
    output logic                     o_valid,
    output logic signed [TEMP_W-1:0] o_temperature,
    output logic [STATUS_W-1:0]      o_status
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_WRITE     = 8'b0000_0010,
        S_CHK_FIRST = 8'b0000_0100,
        S_CHK_LAST  = 8'b0000_1000,
        S_SEARCH    = 8'b0001_0000,
        S_RD_TOP    = 8'b0010_0000,
        S_DIV_INIT  = 8'b0100_0000,
        S_DIV_WAIT  = 8'b1000_0000
    } t_state;

    localparam logic signed [CALC_W-1:0] TEMP_MAX_C = CALC_W'(TEMP_MAX);
    localparam logic signed [CALC_W-1:0] OFFSET_C   = CALC_W'(DEGREE_OFFSET * TENTHS);

    // Sequencer and request registers
    t_state                    r_state, n_state;
    logic [RES_W-1:0]          r_res;
    logic [ENTRY_IDX_W-1:0]    r_idx;
    logic [RES_W-1:0]          r_val;
    logic [IDX_W-1:0]          r_lo, n_lo;
    logic [IDX_W-1:0]          r_hi, n_hi;
    logic [IDX_W-1:0]          r_mid, n_mid;
    logic [RES_W-1:0]          r_base;

    // Result registers
    logic                      r_valid, n_valid;
    logic signed [TEMP_W-1:0]  r_temp, n_temp;
    t_status                   r_status, n_status;

    // RAM and divider hookup
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_raddr;
    logic [RES_W-1:0]          ram_rdata;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    // Datapath helpers
    logic [IDX_W-1:0]          c_lo, c_hi;
    logic [IDX_W:0]            mid_sum;
    logic [IDX_W-1:0]          mid;
    logic [RES_W-1:0]          diff;
    logic [QUOT_W-1:0]         frac;
    logic [CALC_W-1:0]         t_pos;
    logic signed [CALC_W-1:0]  t_sig;
    logic signed [TEMP_W-1:0]  t_out;

    rtd_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (RES_W),
        .AW    (IDX_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IDX_W'(r_idx)),
        .i_wdata (r_val),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rtd_frac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign busy   = (r_state != S_IDLE);
    assign ram_we = (r_state == S_WRITE) && (32'(r_idx) < 32'(TABLE_ENTRIES));

    // Bracket candidate: from the full table on the first probe, else narrowed
    // by the probe that just returned.
    always_comb begin
        c_lo = r_lo;
        c_hi = r_hi;
        if (r_state == S_CHK_LAST) begin
            c_lo = '0;
            c_hi = LAST_IDX;
        end else if (r_res < ram_rdata) begin
            c_hi = r_mid;
        end else begin
            c_lo = r_mid;
        end
    end

    assign mid_sum = {1'b0, c_lo} + {1'b0, c_hi};
    assign mid     = mid_sum[IDX_W:1];

    // Interpolation: resistance at or above base is guaranteed by the search
    assign diff = r_res - r_base;
    assign frac = (r_state == S_DIV_WAIT) ? div_rsp.quot : '0;
    assign t_pos = CALC_W'(r_lo) * CALC_W'(TENTHS) + CALC_W'(frac);
    assign t_sig = signed'(t_pos) - OFFSET_C;
    assign t_out = (t_sig > TEMP_MAX_C) ? TEMP_W'(TEMP_MAX_C) : TEMP_W'(t_sig);

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_valid   = 1'b0;
        n_temp    = r_temp;
        n_status  = r_status;
        ram_raddr = '0;
        div_req.load     = 1'b0;
        div_req.dividend = (DVD_W'(diff) << 3) + (DVD_W'(diff) << 1);
        div_req.divisor  = ram_rdata - r_base;

        unique case (r_state) inside
            S_IDLE: begin
                // Keep the first entry on the read port so it is ready at accept
                if (start) begin
                    n_state = (i_kind == KIND_WRITE) ? S_WRITE : S_CHK_FIRST;
                end
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            S_CHK_FIRST: begin
                ram_raddr = LAST_IDX;
                if (r_res < ram_rdata) begin
                    n_valid  = 1'b1;
                    n_temp   = TEMP_W'(TEMP_BELOW);
                    n_status = ST_BELOW;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_CHK_LAST;
                end
            end
            S_CHK_LAST, S_SEARCH: begin
                if ((r_state == S_CHK_LAST) && (r_res > ram_rdata)) begin
                    n_valid  = 1'b1;
                    n_temp   = TEMP_W'(TEMP_ABOVE);
                    n_status = ST_ABOVE;
                    n_state  = S_IDLE;
                end else begin
                    n_lo = c_lo;
                    n_hi = c_hi;
                    if (mid == c_lo) begin
                        // Bracket closed: fetch the base entry
                        ram_raddr = c_lo;
                        n_state   = S_RD_TOP;
                    end else begin
                        ram_raddr = mid;
                        n_mid     = mid;
                        n_state   = S_SEARCH;
                    end
                end
            end
            S_RD_TOP: begin
                ram_raddr = r_hi;
                n_state   = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                if (ram_rdata > r_base) begin
                    div_req.load = 1'b1;
                    n_state      = S_DIV_WAIT;
                end else begin
                    // Flat interval: no fraction
                    n_valid  = 1'b1;
                    n_temp   = t_out;
                    n_status = ST_INSIDE;
                    n_state  = S_IDLE;
                end
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_valid  = 1'b1;
                    n_temp   = t_out;
                    n_status = ST_INSIDE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_res <= i_resistance;
            r_idx <= i_entry_index;
            r_val <= i_entry_value;
        end
        if (r_state == S_RD_TOP) begin
            r_base <= ram_rdata;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_temp   <= n_temp;
        r_status <= n_status;
    end

    assign o_valid       = r_valid;
    assign o_temperature = r_temp;
    assign o_status      = r_status;

    `ASSERT_TOP(a_accept_busy, start && !busy |=> busy, "accepted request did not raise busy")
    `ASSERT_TOP(a_strobe_idle, o_valid |-> !busy, "result strobe while still busy")
    `ASSERT_TOP(a_strobe_single, o_valid |=> !o_valid, "result strobe longer than one cycle")
    `ASSERT_TOP(a_below_value, o_valid && (o_status == ST_BELOW) |-> o_temperature == TEMP_W'(TEMP_BELOW), "below-range result carries wrong temperature")

endmodule
